FILE: sv/agc_pkg.sv
package agc_pkg;

    // Value width of every amplitude, RMS and limit field (fixed by the field list)
    localparam int VW            = 16;
    localparam int FRAC_BITS_DEF = 12;
    // Deadband is an unsigned Q0.16 fraction of the target
    localparam int DB_FRAC       = 16;
    localparam int CFG_IDX_W     = 3;

    localparam logic [VW-1:0] RST_TARGET   = VW'(4096);
    localparam logic [VW-1:0] RST_DEADBAND = VW'(3277);
    localparam logic [VW-1:0] RST_STEP_MIN = VW'(2048);
    localparam logic [VW-1:0] RST_STEP_MAX = VW'(8192);
    localparam logic [VW-1:0] RST_AMP_MIN  = VW'(205);
    localparam logic [VW-1:0] RST_AMP_MAX  = VW'(4096);

    typedef enum logic [2:0] {
        ACT_DISABLED = 3'd0,
        ACT_CLIP     = 3'd1,
        ACT_SMALL    = 3'd2,
        ACT_DEADBAND = 3'd3,
        ACT_ADJUSTED = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_TARGET   = 3'd1,
        CFG_DEADBAND = 3'd2,
        CFG_STEP_MIN = 3'd3,
        CFG_STEP_MAX = 3'd4,
        CFG_AMP_MIN  = 3'd5,
        CFG_AMP_MAX  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [VW-1:0] measured_rms;
        logic          clipping;
        logic [VW-1:0] present_amp;
    } t_in;

    typedef struct packed {
        logic [VW-1:0] next_amp;
        t_action       action;
    } t_out;

    typedef struct packed {
        logic          enable;
        logic [VW-1:0] target_rms;
        logic [VW-1:0] deadband;
        logic [VW-1:0] step_min;
        logic [VW-1:0] step_max;
        logic [VW-1:0] amp_min;
        logic [VW-1:0] amp_max;
    } t_cfg;

    // Item data that rides along the divider chain untouched
    typedef struct packed {
        logic [VW-1:0] amp;
        logic [VW-1:0] clip_amp;
        t_action       act;
    } t_side;

    typedef struct packed {
        logic [VW-1:0] rms;
        logic [VW-1:0] rem;
        t_side         side;
    } t_div;

    // Smallest RMS worth correcting: 0.001 rounded up to the fraction grid
    function automatic logic [VW-1:0] f_rms_floor(input int frac);
        int v;
        v = ((1 << frac) + 999) / 1000;
        return VW'(v);
    endfunction

endpackage

FILE: sv/agc_front.sv
module agc_front #(
    parameter int FRAC_BITS = agc_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  agc_pkg::t_in   i_data,
    input  agc_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output agc_pkg::t_div  o_data
);
    import agc_pkg::*;

    localparam int PW        = VW + FRAC_BITS;
    localparam int ClipScale = ((4 << FRAC_BITS) + 2) / 5;

    logic [2*VW-1:0] n_thr_prod;
    logic [VW-1:0]   r_thr;
    logic [VW-1:0]   n_amp;

    logic            r_s1_valid;
    logic [VW-1:0]   r_s1_rms;
    logic            r_s1_clip;
    logic [VW-1:0]   r_s1_amp;

    logic [VW-1:0]   n_diff;
    logic [PW-1:0]   n_clip_prod;
    t_action         n_act;

    logic            r_valid;
    t_div            r_data;

    // Deadband threshold depends on configuration only
    assign n_thr_prod = {{VW{1'b0}}, i_cfg.deadband} * {{VW{1'b0}}, i_cfg.target_rms};

    always_ff @(posedge i_clk) begin
        r_thr <= n_thr_prod[DB_FRAC +: VW];
    end

    always_comb begin
        if (i_data.present_amp < i_cfg.amp_min) begin
            n_amp = i_cfg.amp_min;
        end else if (i_data.present_amp > i_cfg.amp_max) begin
            n_amp = i_cfg.amp_max;
        end else begin
            n_amp = i_data.present_amp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_rms  <= i_data.measured_rms;
            r_s1_clip <= i_data.clipping;
            r_s1_amp  <= n_amp;
        end
    end

    assign n_diff = (r_s1_rms > i_cfg.target_rms) ? (r_s1_rms - i_cfg.target_rms)
                                                   : (i_cfg.target_rms - r_s1_rms);
    assign n_clip_prod = {{FRAC_BITS{1'b0}}, r_s1_amp} * PW'(ClipScale);

    always_comb begin
        if (!i_cfg.enable) begin
            n_act = ACT_DISABLED;
        end else if (r_s1_clip) begin
            n_act = ACT_CLIP;
        end else if (r_s1_rms < f_rms_floor(FRAC_BITS)) begin
            n_act = ACT_SMALL;
        end else if (n_diff < r_thr) begin
            n_act = ACT_DEADBAND;
        end else begin
            n_act = ACT_ADJUSTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data.rms           <= r_s1_rms;
            r_data.rem           <= '0;
            r_data.side.amp      <= r_s1_amp;
            r_data.side.clip_amp <= n_clip_prod[FRAC_BITS +: VW];
            r_data.side.act      <= n_act;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/agc_div_cell.sv
module agc_div_cell #(
    parameter int QW = agc_pkg::VW + agc_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  agc_pkg::t_div  i_data,
    input  logic [QW-1:0]  i_quo,
    input  logic           i_num_bit,
    output logic           o_valid,
    output agc_pkg::t_div  o_data,
    output logic [QW-1:0]  o_quo
);
    import agc_pkg::*;

    logic [VW:0]   n_rem_sh;
    logic [VW:0]   n_sub;
    logic          n_ge;
    logic [VW-1:0] n_rem;

    logic          r_valid;
    t_div          r_data;
    logic [QW-1:0] r_quo;

    // One restoring step: bring down a dividend bit, subtract when it fits
    assign n_rem_sh = {i_data.rem, i_num_bit};
    assign n_ge     = n_rem_sh >= {1'b0, i_data.rms};
    assign n_sub    = n_rem_sh - {1'b0, i_data.rms};
    assign n_rem    = n_ge ? n_sub[VW-1:0] : n_rem_sh[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data.rms  <= i_data.rms;
            r_data.rem  <= n_rem;
            r_data.side <= i_data.side;
            r_quo       <= {i_quo[QW-2:0], n_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_quo   = r_quo;

endmodule

FILE: sv/agc_back.sv
module agc_back #(
    parameter int FRAC_BITS = agc_pkg::FRAC_BITS_DEF,
    parameter int QW        = agc_pkg::VW + agc_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  agc_pkg::t_div  i_data,
    input  logic [QW-1:0]  i_quo,
    input  agc_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output agc_pkg::t_out  o_data
);
    import agc_pkg::*;

    localparam int SW = 2 * VW - FRAC_BITS;

    logic [QW-1:0]   n_ratio;
    logic            r_b1_valid;
    logic [VW-1:0]   r_b1_ratio;
    t_side           r_b1_side;

    logic            r_b2_valid;
    logic [2*VW-1:0] r_b2_prod;
    t_side           r_b2_side;

    logic [SW-1:0]   n_pick;
    logic [SW-1:0]   n_lim;
    logic [VW-1:0]   n_next;

    logic            r_valid;
    t_out            r_data;

    // Clamp the quotient to the step limits; the result always fits VW bits
    always_comb begin
        if (i_quo < QW'(i_cfg.step_min)) begin
            n_ratio = QW'(i_cfg.step_min);
        end else if (i_quo > QW'(i_cfg.step_max)) begin
            n_ratio = QW'(i_cfg.step_max);
        end else begin
            n_ratio = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_adv) begin
            r_b1_valid <= i_valid;
            r_b2_valid <= r_b1_valid;
            r_valid    <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b1_ratio <= n_ratio[VW-1:0];
            r_b1_side  <= i_data.side;
            r_b2_prod  <= {{VW{1'b0}}, r_b1_side.amp} * {{VW{1'b0}}, r_b1_ratio};
            r_b2_side  <= r_b1_side;
        end
    end

    assign n_pick = (r_b2_side.act == ACT_ADJUSTED) ? r_b2_prod[2*VW-1:FRAC_BITS]
                                                    : SW'(r_b2_side.clip_amp);

    always_comb begin
        if (n_pick < SW'(i_cfg.amp_min)) begin
            n_lim = SW'(i_cfg.amp_min);
        end else if (n_pick > SW'(i_cfg.amp_max)) begin
            n_lim = SW'(i_cfg.amp_max);
        end else begin
            n_lim = n_pick;
        end
    end

    always_comb begin
        case (r_b2_side.act)
            ACT_ADJUSTED, ACT_CLIP: n_next = n_lim[VW-1:0];
            default:                n_next = r_b2_side.amp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data.next_amp <= n_next;
            r_data.action   <= r_b2_side.act;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/auto_gain_step.sv
// Channel   Signals                                   Direction  Moves
// -------   ---------------------------------------   ---------  ---------------------------
// in        i_in_valid  / o_in_ready  / i_in_data     in         one measurement transaction
// out       o_out_valid / i_out_ready / o_out_data    out        one amplitude transaction
// cfg       i_cfg_valid / o_cfg_ready / i_cfg_index,  in         one register write
//           i_cfg_data
//
// Takes one transaction per cycle while the output is not stalled; each result passes through
// the front-end registers, the divider chain and the back-end registers after its transaction
// is accepted. The divider chain holds one cell per quotient bit of (target << FRAC_BITS) / rms.
// Reset is synchronous, active low; it clears all valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; o_in_ready drops in that same cycle.
// Configuration writes are always taken; every stage reads the registers live, so write them
// only while no transaction is in flight.
module auto_gain_step #(
    parameter int FRAC_BITS = agc_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  agc_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output agc_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [agc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [agc_pkg::VW-1:0]          i_cfg_data
);
    import agc_pkg::*;

    // Quotient width: a VW-bit target shifted up by FRAC_BITS
    localparam int QW = VW + FRAC_BITS;

    t_cfg          r_cfg;
    logic          w_adv;
    logic          w_out_valid;

    logic          w_cell_valid [0:QW];
    t_div          w_cell_data  [0:QW];
    logic [QW-1:0] w_cell_quo   [0:QW];
    logic          w_num_bit    [0:QW-1];

    // Register file: take a write whenever it is offered, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b1;
            r_cfg.target_rms <= RST_TARGET;
            r_cfg.deadband   <= RST_DEADBAND;
            r_cfg.step_min   <= RST_STEP_MIN;
            r_cfg.step_max   <= RST_STEP_MAX;
            r_cfg.amp_min    <= RST_AMP_MIN;
            r_cfg.amp_max    <= RST_AMP_MAX;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ENABLE:   r_cfg.enable     <= i_cfg_data[0];
                CFG_TARGET:   r_cfg.target_rms <= i_cfg_data;
                CFG_DEADBAND: r_cfg.deadband   <= i_cfg_data;
                CFG_STEP_MIN: r_cfg.step_min   <= i_cfg_data;
                CFG_STEP_MAX: r_cfg.step_max   <= i_cfg_data;
                CFG_AMP_MIN:  r_cfg.amp_min    <= i_cfg_data;
                CFG_AMP_MAX:  r_cfg.amp_max    <= i_cfg_data;
                default:      r_cfg            <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Advance every stage together unless the result register is full and not taken
    assign w_adv      = !w_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Front end: clamp the amplitude, rank the rules, prepare the clip backoff
    agc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_cell_valid[0]),
        .o_data  (w_cell_data[0])
    );

    assign w_cell_quo[0] = '0;

    // Divider chain: cell k brings down dividend bit QW-1-k, which is a target bit
    // for the upper VW positions and zero for the FRAC_BITS positions below
    for (genvar k = 0; k < QW; k++) begin : g_cell
        if (QW - 1 - k >= FRAC_BITS) begin : g_tgt
            assign w_num_bit[k] = r_cfg.target_rms[QW - 1 - k - FRAC_BITS];
        end else begin : g_zero
            assign w_num_bit[k] = 1'b0;
        end

        agc_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_valid   (w_cell_valid[k]),
            .i_data    (w_cell_data[k]),
            .i_quo     (w_cell_quo[k]),
            .i_num_bit (w_num_bit[k]),
            .o_valid   (w_cell_valid[k+1]),
            .o_data    (w_cell_data[k+1]),
            .o_quo     (w_cell_quo[k+1])
        );
    end

    // Back end: clamp the ratio, scale the amplitude, clamp and pick the result
    agc_back #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_cell_valid[QW]),
        .i_data  (w_cell_data[QW]),
        .i_quo   (w_cell_quo[QW]),
        .i_cfg   (r_cfg),
        .o_valid (w_out_valid),
        .o_data  (o_out_data)
    );

    assign o_out_valid = w_out_valid;

`ifndef SYNTHESIS
    // The small-signal rule is picked only for an RMS under the floor
    a_small_below_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_valid[0] && w_cell_data[0].side.act == ACT_SMALL
        |-> w_cell_data[0].rms < f_rms_floor(FRAC_BITS))
        else $error("small-signal action with RMS at or above floor");

    // An adjusted transaction never carries a zero divisor into the divider
    a_adjust_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_valid[0] && w_cell_data[0].side.act == ACT_ADJUSTED
        |-> w_cell_data[0].rms >= f_rms_floor(FRAC_BITS) && w_cell_data[0].rms != '0)
        else $error("adjust action with RMS under floor");

    // For an adjusted transaction, the remainder leaving the chain is below the divisor
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_valid[QW] && w_cell_data[QW].side.act == ACT_ADJUSTED
        |-> w_cell_data[QW].rem < w_cell_data[QW].rms)
        else $error("divider remainder not below divisor");
`endif

endmodule
